// File: hw/rtl/prt_pkg.sv
// Package for the pending request table: widths, operation codes,
// command and table entry types shared by the front, back and top level.
// Depends on nothing.
`default_nettype none

package prt_pkg;

  // Fixed field widths.
  localparam int unsigned IdW  = 32;
  localparam int unsigned AgeW = 16;
  localparam int unsigned OpW  = 3;

  // Default table depth and reset value of the time-to-live register.
  localparam int unsigned TableDepthDefault = 16;
  localparam logic [AgeW-1:0] TtlReset = 16'd600;

  // Depth of the command queue between front and back (power of two).
  localparam int unsigned CmdQueueDepth = 2;

  // Raw operation codes on the input port.
  localparam logic [OpW-1:0] OPC_PUSH    = 3'd0;
  localparam logic [OpW-1:0] OPC_TICK    = 3'd1;
  localparam logic [OpW-1:0] OPC_RESOLVE = 3'd2;
  localparam logic [OpW-1:0] OPC_DISMISS = 3'd3;
  localparam logic [OpW-1:0] OPC_CLEAR   = 3'd4;

  // Result kinds.
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  // Classified command; unknown operation codes become CMD_NONE.
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_TICK,
    CMD_RESOLVE,
    CMD_DISMISS,
    CMD_CLEAR,
    CMD_NONE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e        op;
    logic [IdW-1:0] target;
    logic           yes;
    logic           want;
  } cmd_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [AgeW-1:0] age;
    logic            handler;
  } slot_t;

  // One buffered decision event.
  typedef struct packed {
    logic [IdW-1:0] id;
    logic           dec;
  } evt_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_PROC,
    S_APPEND,
    S_DRAIN,
    S_EVRD,
    S_EVOUT,
    S_STATUS
  } back_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/pending_request_table_with_timeout.sv
// Top level of the pending request table with timeout: the time-to-live
// register, the front end with its command queue and the back end.
// Depends on prt_pkg, prt_front and prt_back.
//
// Usage: an item (operation, target id, answer, handler mark) is taken at
// a rising edge where start is high and busy is low; the front queue holds
// up to two items, so busy rises only when both wait behind the back end.
// The back end handles one item at a time. Each removal by eviction,
// expiry or resolve of an entry with a handler gives a decision result,
// and every item ends with one status result (last high). Each result is
// on the result ports for exactly one cycle with event_valid_o high; the
// receiver cannot stall, so nothing waits on it.
// With the back end idle, a push into a table that is not full goes straight
// to the append step. An item that walks the table spends a read step and a
// process step on each entry held, since the slot memory has one registered
// read port, and each buffered decision event then takes a check, a read and
// an output step; a push that evicts walks the table before its append step.
// A queued item enters the back end in the cycle after the previous status
// result.
// Reset empties the table, zeroes the id counter and sets the time-to-live
// to 600; it is written through the cfg channel, which is always ready.
`default_nettype none

module pending_request_table_with_timeout #(
  parameter int unsigned TableDepth = prt_pkg::TableDepthDefault,
  parameter int unsigned CntW       = $clog2(TableDepth + 1)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire  [prt_pkg::OpW-1:0]     operation_i,
  input  wire  [prt_pkg::IdW-1:0]     target_id_i,
  input  wire                         answer_yes_i,
  input  wire                         wants_handler_i,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [prt_pkg::AgeW-1:0]    cfg_data_i,
  output logic                        event_valid_o,
  output logic                        event_kind_o,
  output logic [prt_pkg::IdW-1:0]     event_id_o,
  output logic                        decision_o,
  output logic [CntW-1:0]             entry_count_o,
  output logic                        last_o
);
  import prt_pkg::*;

  logic [AgeW-1:0] ttl_q;
  cmd_t            cmd;
  logic            cmd_valid;
  logic            cmd_pop;

  // Time-to-live register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TtlReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ttl_q <= cfg_data_i;
    end
  end

  // Front end: accept, classify, queue.
  prt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .operation_i     (operation_i),
    .target_id_i     (target_id_i),
    .answer_yes_i    (answer_yes_i),
    .wants_handler_i (wants_handler_i),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop)
  );

  // Back end: table walk and results.
  prt_back #(
    .TableDepth (TableDepth),
    .CntW       (CntW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ttl_i         (ttl_q),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .event_valid_o (event_valid_o),
    .event_kind_o  (event_kind_o),
    .event_id_o    (event_id_o),
    .decision_o    (decision_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/prt_front.sv
// Front end of the pending request table: accepts items, classifies the
// operation code and holds commands in a short queue for the back end.
// Depends on prt_pkg.
`default_nettype none

module prt_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  output logic                       busy_o,
  input  wire  [prt_pkg::OpW-1:0]    operation_i,
  input  wire  [prt_pkg::IdW-1:0]    target_id_i,
  input  wire                        answer_yes_i,
  input  wire                        wants_handler_i,
  output prt_pkg::cmd_t              cmd_o,
  output logic                       cmd_valid_o,
  input  wire                        cmd_pop_i
);
  import prt_pkg::*;

  localparam int unsigned QPtrW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int unsigned QCntW = $clog2(CmdQueueDepth + 1);

  cmd_t             queue_q [CmdQueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  cmd_t             cmd_in;
  logic             push;
  logic             pop;

  // Classify the raw operation code.
  always_comb begin
    cmd_in.target = target_id_i;
    cmd_in.yes    = answer_yes_i;
    cmd_in.want   = wants_handler_i;
    unique case (operation_i)
      OPC_PUSH:    cmd_in.op = CMD_PUSH;
      OPC_TICK:    cmd_in.op = CMD_TICK;
      OPC_RESOLVE: cmd_in.op = CMD_RESOLVE;
      OPC_DISMISS: cmd_in.op = CMD_DISMISS;
      OPC_CLEAR:   cmd_in.op = CMD_CLEAR;
      default:     cmd_in.op = CMD_NONE;
    endcase
  end

  // Queue control.
  assign busy_o      = (count_q == QCntW'(CmdQueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/prt_back.sv
// Back end of the pending request table: slot memory, compaction walk,
// decision event buffer and result sequencing.
// Depends on prt_pkg.
`default_nettype none

module prt_back #(
  parameter int unsigned TableDepth = prt_pkg::TableDepthDefault,
  parameter int unsigned CntW       = $clog2(TableDepth + 1)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  [prt_pkg::AgeW-1:0]    ttl_i,
  input  wire  prt_pkg::cmd_t         cmd_i,
  input  wire                         cmd_valid_i,
  output logic                        cmd_pop_o,
  output logic                        event_valid_o,
  output logic                        event_kind_o,
  output logic [prt_pkg::IdW-1:0]     event_id_o,
  output logic                        decision_o,
  output logic [CntW-1:0]             entry_count_o,
  output logic                        last_o
);
  import prt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  back_state_e     state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] r_q, r_d;
  logic [CntW-1:0] w_q, w_d;
  logic [CntW-1:0] e_q, e_d;
  logic [CntW-1:0] k_q, k_d;
  logic            found_q, found_d;
  logic [IdW-1:0]  id_ctr_q, id_ctr_d;
  logic [IdW-1:0]  status_id_q, status_id_d;

  // Memories with registered read data.
  slot_t           slot_mem [TableDepth];
  slot_t           slot_rd_q;
  evt_t            ev_mem [TableDepth];
  evt_t            ev_rd_q;

  logic            slot_we;
  logic [IdxW-1:0] slot_waddr;
  slot_t           slot_wdata;
  logic            ev_we;
  evt_t            ev_wdata;

  // Per-entry decision for the walk.
  logic [AgeW-1:0] age_inc;
  logic [AgeW-1:0] age_new;
  logic            drop;
  logic            evt;
  logic            evt_dec;
  logic            walk_end;
  logic [CntW-1:0] w_next;
  logic [CntW-1:0] e_next;

  assign age_inc  = (slot_rd_q.age == '1) ? slot_rd_q.age : slot_rd_q.age + AgeW'(1);
  assign walk_end = ((r_q + CntW'(1)) == occ_q);
  assign w_next   = drop ? w_q : w_q + CntW'(1);
  assign e_next   = evt ? e_q + CntW'(1) : e_q;

  always_comb begin
    drop    = 1'b0;
    evt     = 1'b0;
    evt_dec = 1'b0;
    age_new = slot_rd_q.age;
    unique case (cmd_q.op)
      CMD_PUSH: begin
        drop = (r_q == '0);
        evt  = drop && slot_rd_q.handler;
      end
      CMD_TICK: begin
        age_new = age_inc;
        drop    = (age_inc >= ttl_i);
        evt     = drop && slot_rd_q.handler;
      end
      CMD_RESOLVE: begin
        drop    = !found_q && (slot_rd_q.id == cmd_q.target);
        evt     = drop && slot_rd_q.handler;
        evt_dec = cmd_q.yes;
      end
      CMD_DISMISS: begin
        drop = (slot_rd_q.id == cmd_q.target);
      end
      default: begin
        drop = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            CMD_PUSH:    state_d = (occ_q == CntW'(TableDepth)) ? S_RD : S_APPEND;
            CMD_TICK,
            CMD_RESOLVE,
            CMD_DISMISS: state_d = (occ_q == '0) ? S_DRAIN : S_RD;
            default:     state_d = S_STATUS;
          endcase
        end
      end
      S_RD:     state_d = S_PROC;
      S_PROC: begin
        if (!walk_end) begin
          state_d = S_RD;
        end else if (cmd_q.op == CMD_PUSH) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_APPEND: state_d = S_DRAIN;
      S_DRAIN:  state_d = (k_q < e_q) ? S_EVRD : S_STATUS;
      S_EVRD:   state_d = S_EVOUT;
      S_EVOUT:  state_d = S_DRAIN;
      S_STATUS: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath updates and memory write controls.
  always_comb begin
    cmd_d       = cmd_q;
    occ_d       = occ_q;
    r_d         = r_q;
    w_d         = w_q;
    e_d         = e_q;
    k_d         = k_q;
    found_d     = found_q;
    id_ctr_d    = id_ctr_q;
    status_id_d = status_id_q;
    slot_we     = 1'b0;
    slot_waddr  = w_q[IdxW-1:0];
    slot_wdata  = '{id: slot_rd_q.id, age: age_new, handler: slot_rd_q.handler};
    ev_we       = 1'b0;
    ev_wdata    = '{id: slot_rd_q.id, dec: evt_dec};
    cmd_pop_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          cmd_d       = cmd_i;
          r_d         = '0;
          w_d         = '0;
          e_d         = '0;
          k_d         = '0;
          found_d     = 1'b0;
          status_id_d = '0;
          if (cmd_i.op == CMD_CLEAR) begin
            occ_d = '0;
          end
        end
      end
      S_PROC: begin
        slot_we = !drop;
        ev_we   = evt;
        w_d     = w_next;
        e_d     = e_next;
        r_d     = r_q + CntW'(1);
        if (drop) begin
          found_d = 1'b1;
        end
        if (walk_end) begin
          occ_d = w_next;
        end
      end
      S_APPEND: begin
        slot_we     = 1'b1;
        slot_waddr  = occ_q[IdxW-1:0];
        slot_wdata  = '{id: id_ctr_q, age: '0, handler: cmd_q.want};
        occ_d       = occ_q + CntW'(1);
        status_id_d = id_ctr_q;
        id_ctr_d    = id_ctr_q + IdW'(1);
      end
      S_EVOUT: begin
        k_d = k_q + CntW'(1);
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // Result ports.
  always_comb begin
    event_valid_o = (state_q == S_EVOUT) || (state_q == S_STATUS);
    last_o        = (state_q == S_STATUS);
    entry_count_o = occ_q;
    if (state_q == S_STATUS) begin
      event_kind_o = KIND_STATUS;
      event_id_o   = status_id_q;
      decision_o   = 1'b0;
    end else begin
      event_kind_o = KIND_DECISION;
      event_id_o   = ev_rd_q.id;
      decision_o   = ev_rd_q.dec;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '{op: CMD_NONE, target: '0, yes: 1'b0, want: 1'b0};
      occ_q       <= '0;
      r_q         <= '0;
      w_q         <= '0;
      e_q         <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      id_ctr_q    <= '0;
      status_id_q <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      occ_q       <= occ_d;
      r_q         <= r_d;
      w_q         <= w_d;
      e_q         <= e_d;
      k_q         <= k_d;
      found_q     <= found_d;
      id_ctr_q    <= id_ctr_d;
      status_id_q <= status_id_d;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (state_q == S_RD) begin
      slot_rd_q <= slot_mem[r_q[IdxW-1:0]];
    end
  end

  // Event buffer: events wait here until the final count is known.
  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      ev_mem[e_q[IdxW-1:0]] <= ev_wdata;
    end
    if (state_q == S_EVRD) begin
      ev_rd_q <= ev_mem[k_q[IdxW-1:0]];
    end
  end

  // The table never holds more than its depth.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(TableDepth))
    else $error("occupancy exceeds table depth");

  // Compaction never writes ahead of the read pointer.
  a_write_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC) |-> (w_q <= r_q))
    else $error("write pointer ahead of read pointer");

  // No more events than entries read so far.
  a_events_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC) |-> (e_q <= r_q))
    else $error("event count exceeds entries walked");

  // An event read only happens for a buffered event.
  a_event_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVRD) |-> (k_q < e_q))
    else $error("event read beyond buffered events");

endmodule

`default_nettype wire
